>>> rtl/mtp_pkg.sv
package mtp_pkg;

	typedef enum logic [1:0] {
		EV_CHAR,
		EV_SEP,
		EV_END,
		EV_STOP
	} ev_kind_t;

	typedef struct packed {
		ev_kind_t    kind;
		logic [7:0]  ch;
		logic        is_digit;
		logic [3:0]  digit;
		logic        is_skip;
		logic        is_sign;
		logic        is_minus;
	} event_t;

	typedef struct packed {
		logic [14:0] frequency_hz;
		logic [16:0] duration_ms;
		logic [16:0] rest_ms;
		logic        sound;
		logic        melody_done;
	} result_t;

	localparam int unsigned TDATA_OUT_W = 56;
	localparam logic [16:0] NUM_MAX_POS = 17'd65535;
	localparam logic [16:0] NUM_MAX_NEG = 17'd65536;

	function automatic logic [14:0] note_freq(input logic [6:0] idx);
		logic [14:0] f;
		unique case (idx)
			7'd0: f = 15'd16;     7'd1: f = 15'd17;     7'd2: f = 15'd18;
			7'd3: f = 15'd19;     7'd4: f = 15'd21;     7'd5: f = 15'd22;
			7'd6: f = 15'd23;     7'd7: f = 15'd24;     7'd8: f = 15'd26;
			7'd9: f = 15'd28;     7'd10: f = 15'd29;    7'd11: f = 15'd31;
			7'd12: f = 15'd33;    7'd13: f = 15'd35;    7'd14: f = 15'd37;
			7'd15: f = 15'd39;    7'd16: f = 15'd41;    7'd17: f = 15'd44;
			7'd18: f = 15'd46;    7'd19: f = 15'd49;    7'd20: f = 15'd52;
			7'd21: f = 15'd55;    7'd22: f = 15'd58;    7'd23: f = 15'd62;
			7'd24: f = 15'd65;    7'd25: f = 15'd69;    7'd26: f = 15'd73;
			7'd27: f = 15'd78;    7'd28: f = 15'd82;    7'd29: f = 15'd87;
			7'd30: f = 15'd92;    7'd31: f = 15'd98;    7'd32: f = 15'd104;
			7'd33: f = 15'd110;   7'd34: f = 15'd117;   7'd35: f = 15'd123;
			7'd36: f = 15'd131;   7'd37: f = 15'd139;   7'd38: f = 15'd147;
			7'd39: f = 15'd156;   7'd40: f = 15'd165;   7'd41: f = 15'd175;
			7'd42: f = 15'd185;   7'd43: f = 15'd196;   7'd44: f = 15'd208;
			7'd45: f = 15'd220;   7'd46: f = 15'd233;   7'd47: f = 15'd247;
			7'd48: f = 15'd262;   7'd49: f = 15'd277;   7'd50: f = 15'd294;
			7'd51: f = 15'd311;   7'd52: f = 15'd330;   7'd53: f = 15'd349;
			7'd54: f = 15'd370;   7'd55: f = 15'd392;   7'd56: f = 15'd415;
			7'd57: f = 15'd440;   7'd58: f = 15'd466;   7'd59: f = 15'd494;
			7'd60: f = 15'd523;   7'd61: f = 15'd554;   7'd62: f = 15'd587;
			7'd63: f = 15'd622;   7'd64: f = 15'd659;   7'd65: f = 15'd698;
			7'd66: f = 15'd740;   7'd67: f = 15'd784;   7'd68: f = 15'd831;
			7'd69: f = 15'd880;   7'd70: f = 15'd932;   7'd71: f = 15'd988;
			7'd72: f = 15'd1047;  7'd73: f = 15'd1109;  7'd74: f = 15'd1175;
			7'd75: f = 15'd1245;  7'd76: f = 15'd1319;  7'd77: f = 15'd1397;
			7'd78: f = 15'd1480;  7'd79: f = 15'd1568;  7'd80: f = 15'd1661;
			7'd81: f = 15'd1760;  7'd82: f = 15'd1865;  7'd83: f = 15'd1976;
			7'd84: f = 15'd2093;  7'd85: f = 15'd2217;  7'd86: f = 15'd2349;
			7'd87: f = 15'd2489;  7'd88: f = 15'd2637;  7'd89: f = 15'd2794;
			7'd90: f = 15'd2960;  7'd91: f = 15'd3136;  7'd92: f = 15'd3322;
			7'd93: f = 15'd3520;  7'd94: f = 15'd3729;  7'd95: f = 15'd3951;
			7'd96: f = 15'd4186;  7'd97: f = 15'd4435;  7'd98: f = 15'd4699;
			7'd99: f = 15'd4978;  7'd100: f = 15'd5274; 7'd101: f = 15'd5588;
			7'd102: f = 15'd5920; 7'd103: f = 15'd6272; 7'd104: f = 15'd6645;
			7'd105: f = 15'd7040; 7'd106: f = 15'd7459; 7'd107: f = 15'd7902;
			7'd108: f = 15'd8372; 7'd109: f = 15'd8870; 7'd110: f = 15'd9397;
			7'd111: f = 15'd9956; 7'd112: f = 15'd10548; 7'd113: f = 15'd11175;
			7'd114: f = 15'd11840; 7'd115: f = 15'd12544; 7'd116: f = 15'd13290;
			7'd117: f = 15'd14080; 7'd118: f = 15'd14917; 7'd119: f = 15'd15804;
			7'd120: f = 15'd16744;
			default: f = 15'd0;
		endcase
		return f;
	endfunction

endpackage

>>> rtl/mtp_front.sv
module mtp_front (
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	input  logic [7:0]        s_axis_tdata,   // char_code
	input  logic              s_axis_tuser,   // action
	input  logic              q_ready,
	output logic              push,
	output mtp_pkg::event_t   ev
);

	logic [7:0] c;

	assign c             = s_axis_tdata;
	assign s_axis_tready = q_ready;
	assign push          = s_axis_tvalid & q_ready;

	always_comb begin
		ev          = '0;
		ev.ch       = c;
		ev.is_digit = (c >= "0") && (c <= "9");
		ev.digit    = 4'(c - 8'("0"));
		ev.is_skip  = (c == 8'd11) || (c == 8'd12);
		ev.is_sign  = (c == "+") || (c == "-");
		ev.is_minus = (c == "-");
		if (s_axis_tuser) begin
			ev.kind = mtp_pkg::EV_STOP;
		end else if (c == 8'd0) begin
			ev.kind = mtp_pkg::EV_END;
		end else if (c == 8'd32 || c == 8'd9 || c == 8'd10 || c == 8'd13 || c == ",") begin
			ev.kind = mtp_pkg::EV_SEP;
		end else begin
			ev.kind = mtp_pkg::EV_CHAR;
		end
	end

endmodule

>>> rtl/mtp_queue.sv
module mtp_queue #(
	parameter int unsigned DEPTH = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  mtp_pkg::event_t   push_data,
	output logic              ready,
	input  logic              pop,
	output logic              valid,
	output mtp_pkg::event_t   data
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	mtp_pkg::event_t   mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              do_pop;

	assign ready  = (count_q != CNT_W'(DEPTH));
	assign valid  = (count_q != '0);
	assign data   = mem_q[rd_ptr_q];
	assign do_pop = pop & valid;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!push && do_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> rtl/mtp_back.sv
module mtp_back #(
	parameter int unsigned TOKEN_CHARS = 15
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              ev_valid,
	input  mtp_pkg::event_t   ev,
	output logic              ev_pop,
	output logic              out_valid,
	input  logic              out_ready,
	output mtp_pkg::result_t  out_res
);

	localparam int unsigned LEN_W = $clog2(TOKEN_CHARS + 1);

	typedef enum logic [1:0] {
		ST_NOTE,
		ST_DUR,
		ST_REST
	} stage_t;

	typedef enum logic [1:0] {
		PH_LEAD,
		PH_SIGN,
		PH_DIGITS,
		PH_STOPPED
	} phase_t;

	stage_t            stage_q;
	phase_t            phase_q;
	logic [LEN_W-1:0]  len_q;
	logic [7:0]        note_q [3];
	logic [16:0]       acc_q;
	logic              neg_q;
	logic [14:0]       held_freq_q;
	logic [16:0]       held_dur_q;
	logic              out_valid_q;
	mtp_pkg::result_t  out_res_q;

	logic              take;
	logic [3:0]        semi;
	logic              letter_ok;
	logic              oct_ok;
	logic [3:0]        oct;
	logic [6:0]        idx;
	logic [14:0]       tok_freq;
	logic [16:0]       tok_num;
	logic [20:0]       acc_next_w;
	logic [16:0]       acc_next;
	logic              len_room;

	assign take      = ev_valid && (!out_valid_q || out_ready);
	assign ev_pop    = take;
	assign out_valid = out_valid_q;
	assign out_res   = out_res_q;
	assign len_room  = (len_q < LEN_W'(TOKEN_CHARS));

	always_comb begin
		letter_ok = 1'b1;
		unique case (note_q[0])
			"C":     semi = 4'd0;
			"D":     semi = 4'd2;
			"E":     semi = 4'd4;
			"F":     semi = 4'd5;
			"G":     semi = 4'd7;
			"A":     semi = 4'd9;
			"B":     semi = 4'd11;
			default: begin
				semi      = 4'd0;
				letter_ok = 1'b0;
			end
		endcase
		oct_ok = (note_q[1] >= "0") && (note_q[1] <= "9");
		oct    = 4'(note_q[1] - 8'("0"));
		if (len_q >= LEN_W'(3) && note_q[2] == "S") begin
			semi = semi + 4'd1;
		end
		idx = 7'(oct) * 7'd12 + 7'(semi);
		if (len_q >= LEN_W'(2) && letter_ok && oct_ok) begin
			tok_freq = mtp_pkg::note_freq(idx);
		end else begin
			tok_freq = '0;
		end
	end

	always_comb begin
		if (neg_q) begin
			tok_num = 17'(-acc_q);
		end else if (acc_q > mtp_pkg::NUM_MAX_POS) begin
			tok_num = mtp_pkg::NUM_MAX_POS;
		end else begin
			tok_num = acc_q;
		end
		acc_next_w = 21'(acc_q) * 21'd10 + 21'(ev.digit);
		if (acc_next_w > 21'(mtp_pkg::NUM_MAX_NEG)) begin
			acc_next = mtp_pkg::NUM_MAX_NEG;
		end else begin
			acc_next = acc_next_w[16:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_q     <= ST_NOTE;
			phase_q     <= PH_LEAD;
			len_q       <= '0;
			note_q[0]   <= '0;
			note_q[1]   <= '0;
			note_q[2]   <= '0;
			acc_q       <= '0;
			neg_q       <= 1'b0;
			held_freq_q <= '0;
			held_dur_q  <= '0;
			out_valid_q <= 1'b0;
			out_res_q   <= '0;
		end else if (take) begin
			out_valid_q <= 1'b0;
			unique case (ev.kind)
				mtp_pkg::EV_STOP, mtp_pkg::EV_END: begin
					if (ev.kind == mtp_pkg::EV_END) begin
						out_valid_q           <= 1'b1;
						out_res_q             <= '0;
						out_res_q.melody_done <= 1'b1;
						if (len_q != '0 && stage_q == ST_REST) begin
							out_res_q.frequency_hz <= held_freq_q;
							out_res_q.duration_ms  <= held_dur_q;
							out_res_q.rest_ms      <= tok_num;
							out_res_q.sound        <= (held_freq_q != '0) &&
								!held_dur_q[16] && (held_dur_q != '0);
						end
					end
					stage_q     <= ST_NOTE;
					phase_q     <= PH_LEAD;
					len_q       <= '0;
					note_q[0]   <= '0;
					note_q[1]   <= '0;
					note_q[2]   <= '0;
					acc_q       <= '0;
					neg_q       <= 1'b0;
					held_freq_q <= '0;
					held_dur_q  <= '0;
				end
				mtp_pkg::EV_SEP: begin
					if (len_q != '0) begin
						unique case (stage_q)
							ST_NOTE: begin
								held_freq_q <= tok_freq;
								stage_q     <= ST_DUR;
							end
							ST_DUR: begin
								held_dur_q <= tok_num;
								stage_q    <= ST_REST;
							end
							default: begin
								out_valid_q            <= 1'b1;
								out_res_q.frequency_hz <= held_freq_q;
								out_res_q.duration_ms  <= held_dur_q;
								out_res_q.rest_ms      <= tok_num;
								out_res_q.sound        <= (held_freq_q != '0) &&
									!held_dur_q[16] && (held_dur_q != '0);
								out_res_q.melody_done  <= 1'b0;
								stage_q                <= ST_NOTE;
								held_freq_q            <= '0;
								held_dur_q             <= '0;
							end
						endcase
						phase_q   <= PH_LEAD;
						len_q     <= '0;
						note_q[0] <= '0;
						note_q[1] <= '0;
						note_q[2] <= '0;
						acc_q     <= '0;
						neg_q     <= 1'b0;
					end
				end
				default: begin
					if (len_room) begin
						if (len_q < LEN_W'(3)) begin
							note_q[len_q[1:0]] <= ev.ch;
						end
						len_q <= len_q + 1'b1;
						unique case (phase_q)
							PH_LEAD: begin
								if (ev.is_skip) begin
									phase_q <= PH_LEAD;
								end else if (ev.is_sign) begin
									neg_q   <= ev.is_minus;
									phase_q <= PH_SIGN;
								end else if (ev.is_digit) begin
									acc_q   <= 17'(ev.digit);
									phase_q <= PH_DIGITS;
								end else begin
									phase_q <= PH_STOPPED;
								end
							end
							PH_SIGN, PH_DIGITS: begin
								if (ev.is_digit) begin
									acc_q   <= acc_next;
									phase_q <= PH_DIGITS;
								end else begin
									phase_q <= PH_STOPPED;
								end
							end
							default: begin
								phase_q <= PH_STOPPED;
							end
						endcase
					end
				end
			endcase
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule

>>> rtl/melody_triplet_parser_unit.sv
// Channel   Direction  Handshake                      Content
// s_axis    in         s_axis_tvalid / s_axis_tready  one melody text byte or a stop request
// m_axis    out        m_axis_tvalid / m_axis_tready  one tone command or one done item
//
// One input item is accepted per cycle while the input queue has room.
// An accepted byte is first written into the input queue; the parser then takes it from there
// and writes any result that it completes into the output register.
// The parser takes one queued byte per cycle whenever the output register is empty
// or being read in the same cycle, so both sides may stall independently.
// Reset clears the parser state, the queue and the output register at once.
module melody_triplet_parser_unit #(
	parameter int unsigned TOKEN_CHARS = 15,
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // char_code
	input  logic        s_axis_tuser,   // action
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [mtp_pkg::TDATA_OUT_W-1:0] m_axis_tdata, // frequency_hz, duration_ms, rest_ms
	output logic        m_axis_tuser,   // sound
	output logic        m_axis_tlast    // melody_done
);

	logic              q_ready;
	logic              push;
	mtp_pkg::event_t   push_ev;
	logic              q_valid;
	mtp_pkg::event_t   q_ev;
	logic              pop;
	mtp_pkg::result_t  res;

	mtp_front u_front (
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.q_ready       (q_ready),
		.push          (push),
		.ev            (push_ev)
	);

	mtp_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_ev),
		.ready     (q_ready),
		.pop       (pop),
		.valid     (q_valid),
		.data      (q_ev)
	);

	mtp_back #(
		.TOKEN_CHARS (TOKEN_CHARS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.ev_valid  (q_valid),
		.ev        (q_ev),
		.ev_pop    (pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_res   (res)
	);

	assign m_axis_tdata = {7'd0, res.rest_ms, res.duration_ms, res.frequency_hz};
	assign m_axis_tuser = res.sound;
	assign m_axis_tlast = res.melody_done;

endmodule
